[hw/rtl/jise_pkg.sv]
// ----------------------------------------------------------------------------
// jise_pkg
// Types, opcodes and helpers for the JVM integer-subset execute unit.
// ----------------------------------------------------------------------------
package jise_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int NUM_LOCALS_DEF  = 16;

  // JVM opcode bytes handled by the unit
  localparam logic [7:0] OP_ICONST_M1    = 8'h02;
  localparam logic [7:0] OP_ICONST_5     = 8'h08;
  localparam logic [7:0] OP_BIPUSH       = 8'h10;
  localparam logic [7:0] OP_ILOAD_0      = 8'h1A;
  localparam logic [7:0] OP_ILOAD_3      = 8'h1D;
  localparam logic [7:0] OP_ISTORE_0     = 8'h3B;
  localparam logic [7:0] OP_ISTORE_3     = 8'h3E;
  localparam logic [7:0] OP_IADD         = 8'h60;
  localparam logic [7:0] OP_ISUB         = 8'h64;
  localparam logic [7:0] OP_IMUL         = 8'h68;
  localparam logic [7:0] OP_ISHL         = 8'h78;
  localparam logic [7:0] OP_ISHR         = 8'h7A;
  localparam logic [7:0] OP_IINC         = 8'h84;
  localparam logic [7:0] OP_IFEQ         = 8'h99;
  localparam logic [7:0] OP_IFLE         = 8'h9E;
  localparam logic [7:0] OP_IF_ICMPEQ    = 8'h9F;
  localparam logic [7:0] OP_IF_ICMPLE    = 8'hA4;
  localparam logic [7:0] OP_GOTO         = 8'hA7;
  localparam logic [7:0] OP_IRETURN      = 8'hAC;
  localparam logic [7:0] OP_RETURN       = 8'hB1;
  localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hB6;

  localparam logic [4:0] SHIFT_MASK = 5'b11111;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_LOCAL = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    COND_EQ = 3'd0,
    COND_NE = 3'd1,
    COND_LT = 3'd2,
    COND_GE = 3'd3,
    COND_GT = 3'd4,
    COND_LE = 3'd5
  } cond_t;

  // What the stack top registers do for one item
  typedef enum logic [2:0] {
    STK_NONE = 3'd0,
    STK_PUSH = 3'd1,
    STK_POP1 = 3'd2,
    STK_POP2 = 3'd3,
    STK_REPL = 3'd4   // pop two, push one
  } stk_act_t;

  typedef struct packed {
    logic [7:0]  op;
    logic [15:0] operand;
  } instr_t;

  typedef struct packed {
    logic               branch_taken;
    logic signed [15:0] branch_offset;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               halted;
    err_t               error;
  } result_t;

  typedef struct packed {
    logic has1;
    logic has2;
    logic full;
  } stk_stat_t;

  typedef struct packed {
    stk_act_t   act;
    logic       lwe;
    logic [7:0] lidx;
    logic       halt_set;
  } exec_ctl_t;

  // Local slot an item reads: iinc names it, iload_n encodes it in the opcode
  function automatic logic [7:0] lvar_index(input instr_t i);
    return (i.op == OP_IINC) ? i.operand[15:8] : 8'(i.op - OP_ILOAD_0);
  endfunction

  function automatic logic cond_holds(input cond_t c, input logic [31:0] a,
                                      input logic [31:0] b);
    logic lt;
    logic gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(b) < $signed(a);
    case (c)
      COND_EQ: return a == b;
      COND_NE: return a != b;
      COND_LT: return lt;
      COND_GE: return !lt;
      COND_GT: return gt;
      default: return !gt;
    endcase
  endfunction

endpackage

[hw/rtl/jise_ram.sv]
// ----------------------------------------------------------------------------
// jise_ram
// Generic single-write, single-read RAM with registered read (read-old).
// ----------------------------------------------------------------------------
module jise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/jise_exec.sv]
// ----------------------------------------------------------------------------
// jise_exec
// Decode and execute of one instruction against the cached stack top.
// ----------------------------------------------------------------------------
module jise_exec #(
  parameter int NUM_LOCALS = jise_pkg::NUM_LOCALS_DEF
) (
  input  jise_pkg::instr_t    instr,
  input  logic                halt,
  input  jise_pkg::stk_stat_t stat,
  input  logic [31:0]         tos,
  input  logic [31:0]         nos,
  input  logic [31:0]         lvar,
  output jise_pkg::result_t   res,
  output jise_pkg::exec_ctl_t ctl,
  output logic [31:0]         value,
  output logic [31:0]         lwdata
);
  import jise_pkg::*;

  logic [7:0]  op;
  logic [31:0] imm8;
  logic [31:0] alu;
  logic [31:0] cmp_a;
  logic [31:0] cmp_b;
  logic [4:0]  shamt;
  logic        iinc_bad;
  logic        hit;
  cond_t       cond;

  assign op       = instr.op;
  assign imm8     = {{24{instr.operand[7]}}, instr.operand[7:0]};
  assign iinc_bad = {1'b0, instr.operand[15:8]} >= 9'(NUM_LOCALS);
  assign shamt    = tos[4:0] & SHIFT_MASK;

  always_comb begin
    case (op)
      OP_IADD: alu = nos + tos;
      OP_ISUB: alu = nos - tos;
      OP_IMUL: alu = nos * tos;
      OP_ISHL: alu = nos << shamt;
      default: alu = 32'($signed(nos) >>> shamt);
    endcase
  end

  // if<cond> tests top against zero, if_icmp<cond> tests next against top
  always_comb begin
    if (op < OP_IF_ICMPEQ) begin
      cond  = cond_t'(3'(op - OP_IFEQ));
      cmp_a = tos;
      cmp_b = '0;
    end else begin
      cond  = cond_t'(3'(op - OP_IF_ICMPEQ));
      cmp_a = nos;
      cmp_b = tos;
    end
    hit = cond_holds(cond, cmp_a, cmp_b);
  end

  always_comb begin
    res        = '0;
    ctl        = '0;
    value      = '0;
    lwdata     = '0;
    res.halted = halt;
    if (!halt) begin
      if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) begin
        if (stat.full) begin
          res.error = ERR_OVER;
        end else begin
          ctl.act = STK_PUSH;
          value   = {24'b0, op} - 32'd3;
        end
      end else if (op == OP_BIPUSH) begin
        if (stat.full) begin
          res.error = ERR_OVER;
        end else begin
          ctl.act = STK_PUSH;
          value   = imm8;
        end
      end else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3) begin
        if (stat.full) begin
          res.error = ERR_OVER;
        end else begin
          ctl.act = STK_PUSH;
          value   = lvar;
        end
      end else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3) begin
        if (!stat.has1) begin
          res.error = ERR_UNDER;
        end else begin
          ctl.act  = STK_POP1;
          ctl.lwe  = 1'b1;
          ctl.lidx = 8'(op - OP_ISTORE_0);
          lwdata   = tos;
        end
      end else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL ||
                   op == OP_ISHL || op == OP_ISHR) begin
        if (!stat.has2) begin
          res.error = ERR_UNDER;
        end else begin
          ctl.act = STK_REPL;
          value   = alu;
        end
      end else if (op == OP_IINC) begin
        if (iinc_bad) begin
          res.error = ERR_LOCAL;
        end else begin
          ctl.lwe  = 1'b1;
          ctl.lidx = instr.operand[15:8];
          lwdata   = lvar + imm8;
        end
      end else if (op >= OP_IFEQ && op <= OP_IFLE) begin
        if (!stat.has1) begin
          res.error = ERR_UNDER;
        end else begin
          ctl.act = STK_POP1;
          if (hit) begin
            res.branch_taken  = 1'b1;
            res.branch_offset = instr.operand;
          end
        end
      end else if (op >= OP_IF_ICMPEQ && op <= OP_IF_ICMPLE) begin
        if (!stat.has2) begin
          res.error = ERR_UNDER;
        end else begin
          ctl.act = STK_POP2;
          if (hit) begin
            res.branch_taken  = 1'b1;
            res.branch_offset = instr.operand;
          end
        end
      end else if (op == OP_GOTO) begin
        res.branch_taken  = 1'b1;
        res.branch_offset = instr.operand;
      end else if (op == OP_IRETURN || op == OP_RETURN) begin
        ctl.halt_set = 1'b1;
        res.halted   = 1'b1;
      end else if (op == OP_INVOKEVIRTUAL) begin
        if (!stat.has1) begin
          res.error = ERR_UNDER;
        end else begin
          ctl.act         = STK_POP1;
          res.print_valid = 1'b1;
          res.print_value = tos;
        end
      end
    end
  end

endmodule

[hw/rtl/jvm_int_subset_execute_unit_core.sv]
// ----------------------------------------------------------------------------
// jvm_int_subset_execute_unit_core
// Executes one JVM integer instruction per item on an operand stack and a
// local-variable file; reports branch, print, halt and error per item.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  instr   | in  | instr_valid / instr_stall  | instr_t  (op, operand)
//  result  | out | result_valid / result_stall| result_t (branch, print, halt, error)
//
//  One item per cycle sustained while result_stall is low; an accepted item goes
//  from the input register into the result register, which offers it as the result.
//  The top two stack entries live in registers; deeper entries sit in two
//  copies of a RAM so that the third and fourth entries are read each cycle.
//  Reset is synchronous; locals read as zero through per-slot valid bits, so
//  no clearing pass is needed and an item may be accepted right after reset.
//  result_stall holds the result register; the input register then takes at
//  most one more item and instr_stall stays high while that item waits.
// ----------------------------------------------------------------------------
module jvm_int_subset_execute_unit_core #(
  parameter int STACK_DEPTH = jise_pkg::STACK_DEPTH_DEF,
  parameter int NUM_LOCALS  = jise_pkg::NUM_LOCALS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_stall,
  input  jise_pkg::instr_t  instr,
  output logic              result_valid,
  input  logic              result_stall,
  output jise_pkg::result_t result
);
  import jise_pkg::*;

  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int SPW    = $clog2(STACK_DEPTH + 1);
  localparam int LAW    = $clog2(NUM_LOCALS);
  localparam int LSLOTS = 1 << LAW;

  // input register
  logic      s1_valid;
  instr_t    s1;
  logic      accept;
  logic      advance;

  // architectural state
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_next;
  logic [31:0]    tos;
  logic [31:0]    tos_next;
  logic [31:0]    nos;
  logic [31:0]    nos_next;
  logic           halt;
  logic           halt_next;

  // stack spill RAM
  logic           swe;
  logic [SAW-1:0] swaddr;
  logic [SAW-1:0] sra0;
  logic [SAW-1:0] sra1;
  logic [SPW-1:0] sp_m3;
  logic [SPW-1:0] sp_m4;
  logic [SPW-1:0] sp_m2;
  logic [31:0]    srd0;
  logic [31:0]    srd1;
  logic           sbyp;
  logic [31:0]    sbyp_data;
  logic [31:0]    third;

  // locals RAM
  logic [LSLOTS-1:0] lvalid;
  logic              lvld;
  logic              lbyp;
  logic [31:0]       lbyp_data;
  logic [LAW-1:0]    lraddr;
  logic [LAW-1:0]    lwaddr;
  logic              lwe;
  logic [31:0]       lrd;
  logic [31:0]       lvar;
  logic [7:0]        in_lidx;
  logic [7:0]        s1_lidx;

  // execute
  stk_stat_t  stat;
  exec_ctl_t  ctl;
  result_t    res_d;
  logic [31:0] value;
  logic [31:0] lwdata;

  assign advance     = s1_valid && (!result_valid || !result_stall);
  assign instr_stall = s1_valid && !advance;
  assign accept      = instr_valid && !instr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1 <= instr;
    end
  end

  assign stat.has1 = sp != '0;
  assign stat.has2 = sp >= SPW'(2);
  assign stat.full = sp == SPW'(STACK_DEPTH);

  assign third = sbyp ? sbyp_data : srd0;
  assign lvar  = lbyp ? lbyp_data : (lvld ? lrd : 32'd0);

  jise_exec #(
    .NUM_LOCALS(NUM_LOCALS)
  ) u_exec (
    .instr (s1),
    .halt  (halt),
    .stat  (stat),
    .tos   (tos),
    .nos   (nos),
    .lvar  (lvar),
    .res   (res_d),
    .ctl   (ctl),
    .value (value),
    .lwdata(lwdata)
  );

  // stack top update
  always_comb begin
    sp_next   = sp;
    tos_next  = tos;
    nos_next  = nos;
    swe       = 1'b0;
    halt_next = halt;
    if (advance) begin
      halt_next = halt | ctl.halt_set;
      case (ctl.act)
        STK_PUSH: begin
          sp_next  = sp + SPW'(1);
          tos_next = value;
          nos_next = tos;
          swe      = stat.has2;     // old next-of-stack spills to the RAM
        end
        STK_POP1: begin
          sp_next  = sp - SPW'(1);
          tos_next = nos;
          nos_next = third;
        end
        STK_POP2: begin
          sp_next  = sp - SPW'(2);
          tos_next = third;
          nos_next = srd1;
        end
        STK_REPL: begin
          sp_next  = sp - SPW'(1);
          tos_next = value;
          nos_next = third;
        end
        default: begin
          sp_next = sp;
        end
      endcase
    end
  end

  assign sp_m2  = sp - SPW'(2);
  assign sp_m3  = sp_next - SPW'(3);
  assign sp_m4  = sp_next - SPW'(4);
  assign swaddr = sp_m2[SAW-1:0];
  assign sra0   = sp_m3[SAW-1:0];
  assign sra1   = sp_m4[SAW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sp   <= '0;
      halt <= 1'b0;
    end else begin
      sp   <= sp_next;
      halt <= halt_next;
    end
    tos       <= tos_next;
    nos       <= nos_next;
    // a spill lands where the third entry is read in the same cycle
    sbyp      <= swe && (swaddr == sra0);
    sbyp_data <= nos;
  end

  jise_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack_a (
    .clk  (clk),
    .we   (swe),
    .waddr(swaddr),
    .wdata(nos),
    .raddr(sra0),
    .rdata(srd0)
  );

  jise_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack_b (
    .clk  (clk),
    .we   (swe),
    .waddr(swaddr),
    .wdata(nos),
    .raddr(sra1),
    .rdata(srd1)
  );

  // locals: read for the item entering the input register, or re-read for
  // the one held there
  assign in_lidx = lvar_index(instr);
  assign s1_lidx = lvar_index(s1);
  assign lraddr  = accept ? in_lidx[LAW-1:0] : s1_lidx[LAW-1:0];
  assign lwe     = advance && ctl.lwe;
  assign lwaddr  = ctl.lidx[LAW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
    end else if (lwe) begin
      lvalid[lwaddr] <= 1'b1;
    end
    lvld      <= lvalid[lraddr];
    lbyp      <= lwe && (lwaddr == lraddr);
    lbyp_data <= lwdata;
  end

  jise_ram #(
    .WIDTH(32),
    .DEPTH(LSLOTS)
  ) u_locals (
    .clk  (clk),
    .we   (lwe),
    .waddr(lwaddr),
    .wdata(lwdata),
    .raddr(lraddr),
    .rdata(lrd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= res_d;
    end
  end

endmodule

[hw/rtl/jise_checker.sv]
// ----------------------------------------------------------------------------
// jise_checker
// Port-level checks on the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module jise_checker (
  input logic              clk,
  input logic              rst,
  input logic              instr_valid,
  input logic              instr_stall,
  input jise_pkg::instr_t  instr,
  input logic              result_valid,
  input logic              result_stall,
  input jise_pkg::result_t result
);
  import jise_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;
  logic       halt_seen;
  logic [7:0] last_op;

  assign in_acc  = instr_valid && !instr_stall;
  assign out_acc = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      halt_seen <= 1'b0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && result.halted) begin
        halt_seen <= 1'b1;
      end
    end
    if (in_acc) begin
      last_op <= instr.op;
    end
  end

  // a held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // no result without an item in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result without an accepted item");

  // at most two items in flight
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many items in flight");

  // once halted, every later result reports halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && halt_seen |-> result.halted)
    else $error("halt dropped before reset, last op %0h", last_op);

endmodule

bind jvm_int_subset_execute_unit_core jise_checker u_jise_checker (.*);

[verif/jise_exec_checker.sv]
// ----------------------------------------------------------------------------
// jise_exec_checker
// Watches the instr and result channels of the execute unit, runs its own
// stack machine for every accepted item and compares each accepted result,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module jise_exec_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  input  logic              instr_stall,
  input  jise_pkg::instr_t  instr,
  input  logic              result_valid,
  input  logic              result_stall,
  input  jise_pkg::result_t result,
  output int                fail_count,
  output int                pending
);
  import jise_pkg::*;

  logic [31:0] opstack [STACK_DEPTH_DEF];
  logic [31:0] lvars   [NUM_LOCALS_DEF];
  int          depth;
  logic        halt_seen;
  int          results_seen;
  result_t     predicted_q [$];

  function automatic logic [31:0] sext_byte(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic cond_met(input cond_t c, input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    case (c)
      COND_EQ: return a == b;
      COND_NE: return a != b;
      COND_LT: return a < b;
      COND_GE: return a >= b;
      COND_GT: return a > b;
      default: return a <= b;
    endcase
  endfunction

  // Runs one instruction on the shadow machine and returns its result.
  function automatic result_t execute_instr(input instr_t it);
    result_t     r;
    logic [7:0]  op;
    logic [7:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] push_v;
    logic        do_push;
    r = '0;
    op = it.op;
    do_push = 1'b0;
    push_v = '0;
    if (!halt_seen) begin
      if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) begin
        do_push = 1'b1;
        push_v = 32'(op - OP_ICONST_M1) - 32'd1;
      end else if (op == OP_BIPUSH) begin
        do_push = 1'b1;
        push_v = sext_byte(it.operand[7:0]);
      end else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3) begin
        do_push = 1'b1;
        push_v = lvars[op - OP_ILOAD_0];
      end else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3) begin
        if (depth < 1) r.error = ERR_UNDER;
        else begin
          depth--;
          lvars[op - OP_ISTORE_0] = opstack[depth];
        end
      end else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL ||
                   op == OP_ISHL || op == OP_ISHR) begin
        if (depth < 2) r.error = ERR_UNDER;
        else begin
          b = opstack[depth - 1];
          a = opstack[depth - 2];
          case (op)
            OP_IADD: a = a + b;
            OP_ISUB: a = a - b;
            OP_IMUL: a = a * b;
            OP_ISHL: a = a << (b[4:0] & SHIFT_MASK);
            default: a = $signed(a) >>> (b[4:0] & SHIFT_MASK);
          endcase
          depth--;
          opstack[depth - 1] = a;
        end
      end else if (op == OP_IINC) begin
        idx = it.operand[15:8];
        if (idx >= NUM_LOCALS_DEF) r.error = ERR_LOCAL;
        else lvars[idx] = lvars[idx] + sext_byte(it.operand[7:0]);
      end else if (op >= OP_IFEQ && op <= OP_IFLE) begin
        if (depth < 1) r.error = ERR_UNDER;
        else begin
          depth--;
          if (cond_met(cond_t'(3'(op - OP_IFEQ)), opstack[depth], '0)) begin
            r.branch_taken = 1'b1;
            r.branch_offset = it.operand;
          end
        end
      end else if (op >= OP_IF_ICMPEQ && op <= OP_IF_ICMPLE) begin
        if (depth < 2) r.error = ERR_UNDER;
        else begin
          b = opstack[depth - 1];
          a = opstack[depth - 2];
          depth -= 2;
          if (cond_met(cond_t'(3'(op - OP_IF_ICMPEQ)), a, b)) begin
            r.branch_taken = 1'b1;
            r.branch_offset = it.operand;
          end
        end
      end else if (op == OP_GOTO) begin
        r.branch_taken = 1'b1;
        r.branch_offset = it.operand;
      end else if (op == OP_IRETURN || op == OP_RETURN) begin
        halt_seen = 1'b1;
      end else if (op == OP_INVOKEVIRTUAL) begin
        if (depth < 1) r.error = ERR_UNDER;
        else begin
          depth--;
          r.print_valid = 1'b1;
          r.print_value = opstack[depth];
        end
      end
      if (do_push) begin
        if (depth >= STACK_DEPTH_DEF) r.error = ERR_OVER;
        else begin
          opstack[depth] = push_v;
          depth++;
        end
      end
    end
    r.halted = halt_seen;
    return r;
  endfunction

  task automatic report_fail(input string msg);
    $display("ERROR @%0t result #%0d: %s", $time, results_seen, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_fail($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      depth = 0;
      halt_seen = 1'b0;
      foreach (lvars[i]) lvars[i] = '0;
      predicted_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_q.size() == 0) begin
          report_fail("result with no item outstanding");
        end else begin
          want = predicted_q.pop_front();
          check_field("branch_taken", 32'(result.branch_taken), 32'(want.branch_taken));
          check_field("branch_offset", 32'(result.branch_offset), 32'(want.branch_offset));
          check_field("print_valid", 32'(result.print_valid), 32'(want.print_valid));
          check_field("print_value", result.print_value, want.print_value);
          check_field("halted", 32'(result.halted), 32'(want.halted));
          check_field("error", 32'(result.error), 32'(want.error));
        end
        results_seen++;
      end
      if (instr_valid && !instr_stall) predicted_q.push_back(execute_instr(instr));
    end
    pending = predicted_q.size();
  end

endmodule

[verif/jvm_int_subset_execute_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// jvm_int_subset_execute_unit_core_tb
// Drives directed and random instruction streams into the execute unit with
// random idling on both channels, a long result hold-off and drain pauses;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module jvm_int_subset_execute_unit_core_tb;
  import jise_pkg::*;

  localparam int RANDOM_ITEMS   = 1270;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic    clk = 1'b0;
  logic    rst;
  logic    instr_valid;
  logic    instr_stall;
  instr_t  instr;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      fail_count;
  int      pending;

  logic    gaps_on   = 1'b1;
  logic    stall_on  = 1'b1;
  logic    hold_req  = 1'b0;
  logic    hold_done = 1'b0;

  always #5 clk = ~clk;

  jvm_int_subset_execute_unit_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  jise_exec_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // push_pct steers the stack depth: high values walk toward overflow.
  function automatic instr_t random_instr(input int push_pct);
    instr_t it;
    int     r;
    it.operand = 16'($urandom);
    it.op = OP_GOTO;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.op = OP_IINC;
      if ($urandom_range(0, 7) == 0)
        it.operand[15:8] = 8'($urandom_range(NUM_LOCALS_DEF, 255));
      else
        it.operand[15:8] = 8'($urandom_range(0, NUM_LOCALS_DEF - 1));
    end else if (r < 11) begin
      it.op = OP_GOTO;
    end else if (r < 15) begin
      // any opcode except the halting ones, which end the run
      do it.op = 8'($urandom); while (it.op == OP_RETURN || it.op == OP_IRETURN);
    end else if ($urandom_range(0, 99) < push_pct) begin
      case ($urandom_range(0, 2))
        0:       it.op = OP_ICONST_M1 + 8'($urandom_range(0, 6));
        1:       it.op = OP_BIPUSH;
        default: it.op = OP_ILOAD_0 + 8'($urandom_range(0, 3));
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0, 1: begin
          case ($urandom_range(0, 4))
            0:       it.op = OP_IADD;
            1:       it.op = OP_ISUB;
            2:       it.op = OP_IMUL;
            3:       it.op = OP_ISHL;
            default: it.op = OP_ISHR;
          endcase
        end
        2:       it.op = OP_ISTORE_0 + 8'($urandom_range(0, 3));
        3:       it.op = OP_IFEQ + 8'($urandom_range(0, 5));
        4:       it.op = OP_IF_ICMPEQ + 8'($urandom_range(0, 5));
        default: it.op = OP_INVOKEVIRTUAL;
      endcase
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] op, input logic [15:0] operand);
    int gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    instr <= instr_t'{op: op, operand: operand};
    instr_valid <= 1'b1;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    instr_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int run_len;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_on) begin
        result_stall <= 1'b1;
        repeat (idle_len() + 1) @(negedge clk);
      end
      result_stall <= 1'b0;
      run_len = $urandom_range(1, 25);
      @(negedge clk);
      for (int i = 1; i < run_len && !(hold_req && !hold_done); i++) @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (instr_valid && !instr_stall) || (result_valid && !result_stall))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int     items;
    int     seg;
    int     seg_len;
    int     push_pct;
    instr_t it;
    rst = 1'b1;
    instr_valid = 1'b0;
    instr = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty-stack underflows and a bad iinc index
    send_item(OP_ISTORE_0, 16'h0000);
    send_item(OP_INVOKEVIRTUAL, 16'hFFFF);
    send_item(OP_IADD, 16'h0000);
    send_item(OP_IINC, 16'h1080);
    // iinc with negative constant, then read back through iload
    send_item(OP_IINC, 16'h0380);
    send_item(OP_ILOAD_3, 16'h0000);
    // shift count above 31 is masked: 1 << 63 gives the sign bit
    send_item(OP_ICONST_M1 + 8'd2, 16'h0000);
    send_item(OP_BIPUSH, 16'h003F);
    send_item(OP_ISHL, 16'h0000);
    send_item(OP_ICONST_M1 + 8'd5, 16'h0000);
    send_item(OP_ISHR, 16'h0000);
    send_item(OP_ISUB, 16'h0000);
    send_item(OP_INVOKEVIRTUAL, 16'h0000);
    send_item(OP_ICONST_5, 16'h0000);
    send_item(OP_ICONST_5, 16'h0000);
    send_item(OP_IF_ICMPEQ, 16'h8000);
    send_item(OP_IFEQ, 16'h1234);
    send_item(OP_ICONST_M1, 16'hFFFF);
    send_item(OP_IFEQ + 8'd3, 16'h7FFF);
    send_item(OP_GOTO, 16'hFFFF);
    send_item(OP_BIPUSH, 16'hFF80);
    send_item(OP_BIPUSH, 16'h007F);
    send_item(OP_IMUL, 16'h0000);
    send_item(OP_ISTORE_0 + 8'd1, 16'h0000);
    send_item(8'h00, 16'hFFFF);

    items = 0;
    seg = 0;
    while (items < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 80);
      push_pct = $urandom_range(30, 70);
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if (seg == 3) begin
        push_pct = 100;       // run into overflow
        seg_len = 95;
      end else if (seg == 4) begin
        push_pct = 0;         // and back down into underflow
        seg_len = 95;
      end
      if (seg == 6) begin
        hold_req = 1'b1;      // long result hold-off while items keep coming
        gaps_on = 1'b0;
      end
      if (seg == 8 || (seg != 6 && $urandom_range(0, 9) == 0)) wait_drain();
      repeat (seg_len) begin
        it = random_instr(push_pct);
        send_item(it.op, it.operand);
        items++;
      end
      seg++;
    end

    // halt, then items that must be ignored
    send_item(OP_RETURN, 16'h0000);
    send_item(OP_IRETURN, 16'h0000);
    send_item(OP_ICONST_5, 16'h0000);
    send_item(OP_GOTO, 16'h0004);
    send_item(OP_INVOKEVIRTUAL, 16'h0000);
    instr_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
